### rtl/core/tsgd_pkg.sv
`timescale 1ns / 1ps

package tsgd_pkg;

  // Width of every configuration register.
  localparam int REG_BITS = 12;

  // APB data and address widths.
  localparam int APB_DATA_BITS = 32;
  localparam int REG_COUNT     = 6;
  localparam int IDX_BITS      = 3;
  localparam int APB_ADDR_BITS = IDX_BITS + 2;

  localparam int KIND_BITS    = 2;
  localparam int GESTURE_BITS = 3;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_QUERY   = 2'd2
  } kind_t;

  typedef enum logic [GESTURE_BITS-1:0] {
    GEST_NONE  = 3'd0,
    GEST_RIGHT = 3'd1,
    GEST_LEFT  = 3'd2,
    GEST_DOWN  = 3'd3,
    GEST_UP    = 3'd4
  } gesture_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_START_X_MIN      = 3'd0,
    REG_START_X_MAX      = 3'd1,
    REG_START_Y_MIN      = 3'd2,
    REG_START_Y_MAX      = 3'd3,
    REG_MIN_TRAVEL       = 3'd4,
    REG_MAX_CROSS_TRAVEL = 3'd5
  } reg_idx_t;

  localparam logic [REG_BITS-1:0] RST_START_X_MIN      = 12'd0;
  localparam logic [REG_BITS-1:0] RST_START_X_MAX      = 12'd4095;
  localparam logic [REG_BITS-1:0] RST_START_Y_MIN      = 12'd0;
  localparam logic [REG_BITS-1:0] RST_START_Y_MAX      = 12'd4095;
  localparam logic [REG_BITS-1:0] RST_MIN_TRAVEL       = 12'd100;
  localparam logic [REG_BITS-1:0] RST_MAX_CROSS_TRAVEL = 12'd50;

  typedef struct packed {
    logic [REG_BITS-1:0] start_x_min;
    logic [REG_BITS-1:0] start_x_max;
    logic [REG_BITS-1:0] start_y_min;
    logic [REG_BITS-1:0] start_y_max;
    logic [REG_BITS-1:0] min_travel;
    logic [REG_BITS-1:0] max_cross_travel;
  } cfg_t;

endpackage

### rtl/core/tsgd_in_if.sv
`timescale 1ns / 1ps

interface tsgd_in_if #(
  parameter int COORD_BITS = 12
);
  logic                                valid;
  logic                                ready;
  logic [tsgd_pkg::KIND_BITS-1:0]      kind;
  logic [COORD_BITS-1:0]               pos_x;
  logic [COORD_BITS-1:0]               pos_y;

  modport source (output valid, kind, pos_x, pos_y, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, output ready);
endinterface

### rtl/core/tsgd_out_if.sv
`timescale 1ns / 1ps

interface tsgd_out_if;
  logic                                valid;
  logic                                ready;
  logic [tsgd_pkg::GESTURE_BITS-1:0]   gesture;

  modport source (output valid, gesture, input ready);
  modport sink   (input valid, gesture, output ready);
endinterface

### rtl/core/touch_swipe_gesture_detector.sv
`timescale 1ns / 1ps

// Swipe gesture detector. It takes one item per clock cycle on in_ch: a touch
// sample, a touch release or a gesture query, selected by kind. Every item is
// first captured in an input register and is then worked off by a short
// compare-and-subtract path that updates the touch state and, for a query,
// loads the output register, which presents the result on out_ch. Samples
// and releases produce no result. The input side stays ready in every cycle
// except when a query sits in the input register while the output register
// still holds an untaken result; then in_ch.ready drops until out_ch takes
// that result. The six window and travel registers sit on an APB port at
// byte addresses 0, 4, 8, 12, 16 and 20 and are written only while the
// detector is idle, as the user must ensure; no logic in the block enforces it.
module touch_swipe_gesture_detector #(
  parameter int COORD_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  tsgd_in_if.sink                               in_ch,
  tsgd_out_if.source                            out_ch,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tsgd_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [tsgd_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [tsgd_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                  pready
);

  tsgd_pkg::cfg_t cfg;

  tsgd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register.
  logic                             s1_valid_r;
  logic                             s1_valid_nxt;
  tsgd_pkg::kind_t                  s1_kind_r;
  logic [COORD_BITS-1:0]            s1_x_r;
  logic [COORD_BITS-1:0]            s1_y_r;

  // Touch state, cleared at reset as the current point is used even when stale.
  logic                             pressed_r, pressed_nxt;
  logic                             armed_r, armed_nxt;
  logic [COORD_BITS-1:0]            start_x_r, start_x_nxt;
  logic [COORD_BITS-1:0]            start_y_r, start_y_nxt;
  logic [COORD_BITS-1:0]            now_x_r, now_x_nxt;
  logic [COORD_BITS-1:0]            now_y_r, now_y_nxt;

  // Output register.
  logic                             out_valid_r, out_valid_nxt;
  tsgd_pkg::gesture_t               gesture_r, gesture_nxt;

  logic                             s1_query;
  logic                             s1_go;
  logic                             accept;
  logic                             in_window;
  tsgd_pkg::gesture_t               class_g;

  tsgd_classify #(
    .COORD_BITS (COORD_BITS)
  ) u_classify (
    .start_x   (start_x_r),
    .start_y   (start_y_r),
    .now_x     (now_x_r),
    .now_y     (now_y_r),
    .cfg       (cfg),
    .in_window (in_window),
    .gesture   (class_g)
  );

  // A query may only leave the input register when the output register is
  // free or is handing its result over in this cycle.
  assign s1_query     = (s1_kind_r == tsgd_pkg::KIND_QUERY);
  assign s1_go        = s1_valid_r && !(s1_query && out_valid_r && !out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_go;
  assign accept       = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = accept || (s1_valid_r && !s1_go);

  always_comb begin
    pressed_nxt   = pressed_r;
    armed_nxt     = armed_r;
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    now_x_nxt     = now_x_r;
    now_y_nxt     = now_y_r;
    gesture_nxt   = gesture_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (s1_go) begin
      case (s1_kind_r)
        tsgd_pkg::KIND_SAMPLE: begin
          // The first sample of a press fixes the start point.
          if (!pressed_r) begin
            start_x_nxt = s1_x_r;
            start_y_nxt = s1_y_r;
            pressed_nxt = 1'b1;
          end else begin
            now_x_nxt = s1_x_r;
            now_y_nxt = s1_y_r;
          end
        end
        tsgd_pkg::KIND_RELEASE: begin
          if (pressed_r) begin
            armed_nxt = 1'b1;
          end
          pressed_nxt = 1'b0;
        end
        tsgd_pkg::KIND_QUERY: begin
          // An out-of-window start answers none and keeps the gesture armed.
          out_valid_nxt = 1'b1;
          if (armed_r && in_window) begin
            gesture_nxt = class_g;
            armed_nxt   = 1'b0;
          end else begin
            gesture_nxt = tsgd_pkg::GEST_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pressed_r   <= 1'b0;
      armed_r     <= 1'b0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      now_x_r     <= '0;
      now_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      pressed_r   <= pressed_nxt;
      armed_r     <= armed_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      now_x_r     <= now_x_nxt;
      now_y_r     <= now_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= tsgd_pkg::kind_t'(in_ch.kind);
      s1_x_r    <= in_ch.pos_x;
      s1_y_r    <= in_ch.pos_y;
    end
    gesture_r <= gesture_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.gesture = gesture_r;

endmodule

### rtl/core/tsgd_regs.sv
`timescale 1ns / 1ps

// APB register file holding the start window and travel limits.
module tsgd_regs (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tsgd_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [tsgd_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [tsgd_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                  pready,
  output tsgd_pkg::cfg_t                        cfg
);

  tsgd_pkg::cfg_t                      cfg_r;
  tsgd_pkg::cfg_t                      cfg_nxt;
  tsgd_pkg::reg_idx_t                  idx;
  logic                                wr_en;
  logic [tsgd_pkg::REG_BITS-1:0]       wval;
  logic [tsgd_pkg::REG_BITS-1:0]       rval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = tsgd_pkg::reg_idx_t'(paddr[tsgd_pkg::APB_ADDR_BITS-1:2]);
  assign wval   = pwdata[tsgd_pkg::REG_BITS-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        tsgd_pkg::REG_START_X_MIN:      cfg_nxt.start_x_min      = wval;
        tsgd_pkg::REG_START_X_MAX:      cfg_nxt.start_x_max      = wval;
        tsgd_pkg::REG_START_Y_MIN:      cfg_nxt.start_y_min      = wval;
        tsgd_pkg::REG_START_Y_MAX:      cfg_nxt.start_y_max      = wval;
        tsgd_pkg::REG_MIN_TRAVEL:       cfg_nxt.min_travel       = wval;
        tsgd_pkg::REG_MAX_CROSS_TRAVEL: cfg_nxt.max_cross_travel = wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tsgd_pkg::REG_START_X_MIN:      rval = cfg_r.start_x_min;
      tsgd_pkg::REG_START_X_MAX:      rval = cfg_r.start_x_max;
      tsgd_pkg::REG_START_Y_MIN:      rval = cfg_r.start_y_min;
      tsgd_pkg::REG_START_Y_MAX:      rval = cfg_r.start_y_max;
      tsgd_pkg::REG_MIN_TRAVEL:       rval = cfg_r.min_travel;
      tsgd_pkg::REG_MAX_CROSS_TRAVEL: rval = cfg_r.max_cross_travel;
      default:                        rval = '0;
    endcase
  end

  assign prdata = tsgd_pkg::APB_DATA_BITS'(rval);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_x_min      <= tsgd_pkg::RST_START_X_MIN;
      cfg_r.start_x_max      <= tsgd_pkg::RST_START_X_MAX;
      cfg_r.start_y_min      <= tsgd_pkg::RST_START_Y_MIN;
      cfg_r.start_y_max      <= tsgd_pkg::RST_START_Y_MAX;
      cfg_r.min_travel       <= tsgd_pkg::RST_MIN_TRAVEL;
      cfg_r.max_cross_travel <= tsgd_pkg::RST_MAX_CROSS_TRAVEL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/tsgd_classify.sv
`timescale 1ns / 1ps

// Start window check and swipe direction from the stored points.
module tsgd_classify #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]  start_x,
  input  logic [COORD_BITS-1:0]  start_y,
  input  logic [COORD_BITS-1:0]  now_x,
  input  logic [COORD_BITS-1:0]  now_y,
  input  tsgd_pkg::cfg_t         cfg,
  output logic                   in_window,
  output tsgd_pkg::gesture_t     gesture
);

  localparam int MW = (COORD_BITS > tsgd_pkg::REG_BITS) ? COORD_BITS : tsgd_pkg::REG_BITS;
  localparam int VW = MW + 2;

  logic signed [VW-1:0] dx;
  logic signed [VW-1:0] dy;
  logic signed [VW-1:0] adx;
  logic signed [VW-1:0] ady;
  logic signed [VW-1:0] lim;
  logic signed [VW-1:0] cross_lim;

  assign in_window = (MW'(start_x) >= MW'(cfg.start_x_min)) &&
                     (MW'(start_x) <= MW'(cfg.start_x_max)) &&
                     (MW'(start_y) >= MW'(cfg.start_y_min)) &&
                     (MW'(start_y) <= MW'(cfg.start_y_max));

  assign dx        = $signed(VW'(now_x)) - $signed(VW'(start_x));
  assign dy        = $signed(VW'(now_y)) - $signed(VW'(start_y));
  assign adx       = dx[VW-1] ? -dx : dx;
  assign ady       = dy[VW-1] ? -dy : dy;
  assign lim       = $signed(VW'(cfg.min_travel));
  assign cross_lim = $signed(VW'(cfg.max_cross_travel));

  // Horizontal swipes take priority over vertical ones.
  always_comb begin
    if (dx > lim && ady < cross_lim) begin
      gesture = tsgd_pkg::GEST_RIGHT;
    end else if (dx < -lim && ady < cross_lim) begin
      gesture = tsgd_pkg::GEST_LEFT;
    end else if (dy > lim && adx < cross_lim) begin
      gesture = tsgd_pkg::GEST_DOWN;
    end else if (dy < -lim && adx < cross_lim) begin
      gesture = tsgd_pkg::GEST_UP;
    end else begin
      gesture = tsgd_pkg::GEST_NONE;
    end
  end

endmodule

### dv/tb_touch_swipe_gesture_detector.sv
`timescale 1ns / 1ps

module tb_touch_swipe_gesture_detector;

  localparam int COORD_BITS = 12;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int KIND_W     = tsgd_pkg::KIND_BITS;
  localparam int REG_W      = tsgd_pkg::REG_BITS;
  localparam int ADDR_W     = tsgd_pkg::APB_ADDR_BITS;
  localparam int DATA_W     = tsgd_pkg::APB_DATA_BITS;
  // The kind code that the block leaves unused.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  // Cycles without any transfer on either channel before the run is declared hung.
  // The slowest correct stretch is a register sweep or a drain with long stalls.
  localparam int HANG_LIMIT = 4000;

  // Tracked touch state of the detector, kept in step with every accepted item.
  typedef struct {
    bit                    pressed;
    bit                    armed;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] now_x;
    logic [COORD_BITS-1:0] now_y;
  } touch_track_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  tsgd_in_if #(.COORD_BITS(COORD_BITS)) in_ch ();
  tsgd_out_if out_ch ();

  touch_swipe_gesture_detector #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predicted touch state and the register copy that the classification uses.
  touch_track_t   track;
  tsgd_pkg::cfg_t win_cfg;

  // Gestures that queries have been predicted to return, oldest first.
  tsgd_pkg::gesture_t pending_gestures[$];

  int  mismatch_count;
  int  items_sent;
  int  idle_cycles;
  bit  in_gaps_on;
  bit  out_stalls_on;

  // The clock toggles every half period of 6 ns.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Classifies the move from the start point to the current point. Travel along
  // the swipe axis must exceed min_travel with its sign, and the travel across
  // it must stay strictly below max_cross_travel. Right wins over left, left
  // over down, and down over up.
  function automatic tsgd_pkg::gesture_t classify_swipe();
    int dx;
    int dy;
    int lim;
    int cross_lim;
    int adx;
    int ady;
    dx        = int'(track.now_x) - int'(track.start_x);
    dy        = int'(track.now_y) - int'(track.start_y);
    lim       = int'(win_cfg.min_travel);
    cross_lim = int'(win_cfg.max_cross_travel);
    adx       = (dx < 0) ? -dx : dx;
    ady       = (dy < 0) ? -dy : dy;
    if (dx > lim && ady < cross_lim) return tsgd_pkg::GEST_RIGHT;
    if (dx < -lim && ady < cross_lim) return tsgd_pkg::GEST_LEFT;
    if (dy > lim && adx < cross_lim) return tsgd_pkg::GEST_DOWN;
    if (dy < -lim && adx < cross_lim) return tsgd_pkg::GEST_UP;
    return tsgd_pkg::GEST_NONE;
  endfunction

  // Advances the tracked touch state by one accepted item. Returns 1 when the
  // item is a query, which always produces exactly one gesture result.
  function automatic bit track_touch_item(input logic [KIND_W-1:0] kind,
                                          input logic [COORD_BITS-1:0] x,
                                          input logic [COORD_BITS-1:0] y,
                                          output tsgd_pkg::gesture_t gest);
    bit in_win;
    bit answers;
    gest    = tsgd_pkg::GEST_NONE;
    answers = 1'b0;
    case (kind)
      tsgd_pkg::KIND_SAMPLE: begin
        // The first sample of a press only records the start point; the current
        // point keeps whatever value it had from an earlier press.
        if (!track.pressed) begin
          track.start_x = x;
          track.start_y = y;
          track.pressed = 1'b1;
        end else begin
          track.now_x = x;
          track.now_y = y;
        end
      end
      tsgd_pkg::KIND_RELEASE: begin
        // A release without a press changes nothing.
        if (track.pressed) track.armed = 1'b1;
        track.pressed = 1'b0;
      end
      tsgd_pkg::KIND_QUERY: begin
        answers = 1'b1;
        in_win  = track.start_x >= win_cfg.start_x_min &&
                  track.start_x <= win_cfg.start_x_max &&
                  track.start_y >= win_cfg.start_y_min &&
                  track.start_y <= win_cfg.start_y_max;
        // A query outside the window answers none but keeps the gesture armed.
        // Inside the window the gesture is disarmed, even when none is found.
        if (track.armed && in_win) begin
          gest        = classify_swipe();
          track.armed = 1'b0;
        end
      end
      default: begin
        // The fourth kind code is unused and the block ignores it.
      end
    endcase
    return answers;
  endfunction

  // ---------------------------------------------------------------------------
  // Input channel driver
  // ---------------------------------------------------------------------------

  // Sends one item and waits for its transfer. Inputs move at the falling edge
  // and the handshake is sampled at the rising edge. Valid stays high across
  // back-to-back items, and idle cycles carry random payload to show that the
  // block looks at the payload only when valid is high.
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [COORD_BITS-1:0] x,
                           input logic [COORD_BITS-1:0] y);
    int                 gap;
    tsgd_pkg::gesture_t gest;
    if ($urandom_range(0, 39) == 0) in_gaps_on = !in_gaps_on;
    gap = in_gaps_on ? $urandom_range(0, 11) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      in_ch.kind  <= KIND_W'($urandom_range(0, 3));
      in_ch.pos_x <= COORD_BITS'($urandom_range(0, COORD_MAX));
      in_ch.pos_y <= COORD_BITS'($urandom_range(0, COORD_MAX));
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.pos_x <= x;
    in_ch.pos_y <= y;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (track_touch_item(kind, x, y, gest)) pending_gestures.push_back(gest);
    if (kind != KIND_SPARE) items_sent++;
  endtask

  // Lowers valid and waits until every predicted gesture has come out, then
  // lets the pipeline settle so that the block is idle.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_gestures.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: ready with random stalls, and the checker
  // ---------------------------------------------------------------------------

  initial begin
    out_ch.ready  = 1'b0;
    out_stalls_on = 1'b1;
    @(posedge rst_n);
    forever begin
      int stall;
      if ($urandom_range(0, 29) == 0) out_stalls_on = !out_stalls_on;
      stall = out_stalls_on ? $urandom_range(0, 11) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // Every result transfer is matched against the oldest predicted gesture.
  always @(posedge clk) begin
    tsgd_pkg::gesture_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_gestures.size() == 0) begin
        $display("%0t ns: unexpected result, expected nothing, actual gesture %0d",
                 $time, out_ch.gesture);
        mismatch_count++;
      end else begin
        want = pending_gestures.pop_front();
        if (out_ch.gesture !== want) begin
          $display("%0t ns: gesture mismatch, expected %0d (%s), actual %0d",
                   $time, want, want.name(), out_ch.gesture);
          mismatch_count++;
        end
      end
    end
  end

  // The watchdog counts cycles in which neither channel has a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, HANG_LIMIT);
      $display("** touch_swipe_gesture_detector: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  // One register access: a setup phase, then an access phase that completes at
  // the rising edge where pready is high. Unused upper data bits are random.
  task automatic apb_access(input bit is_write, input tsgd_pkg::reg_idx_t idx,
                            input logic [REG_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    logic [DATA_W-1:0] word;
    word              = $urandom;
    word[REG_W-1:0]   = wdata;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg_read(input tsgd_pkg::reg_idx_t idx,
                                input logic [REG_W-1:0] want);
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd[REG_W-1:0] !== want) begin
      $display("%0t ns: register %s readback mismatch, expected %0d, actual %0d",
               $time, idx.name(), want, rd[REG_W-1:0]);
      mismatch_count++;
    end
  endtask

  // Writes one register, mirrors it in the predictor and reads it back.
  task automatic program_reg(input tsgd_pkg::reg_idx_t idx,
                             input logic [REG_W-1:0] value);
    logic [DATA_W-1:0] unused_rd;
    apb_access(1'b1, idx, value, unused_rd);
    case (idx)
      tsgd_pkg::REG_START_X_MIN:      win_cfg.start_x_min      = value;
      tsgd_pkg::REG_START_X_MAX:      win_cfg.start_x_max      = value;
      tsgd_pkg::REG_START_Y_MIN:      win_cfg.start_y_min      = value;
      tsgd_pkg::REG_START_Y_MAX:      win_cfg.start_y_max      = value;
      tsgd_pkg::REG_MIN_TRAVEL:       win_cfg.min_travel       = value;
      tsgd_pkg::REG_MAX_CROSS_TRAVEL: win_cfg.max_cross_travel = value;
      default: ;
    endcase
    check_reg_read(idx, value);
  endtask

  // Waits for the block to go idle and then loads a complete setting.
  task automatic apply_setting(input int x_lo, input int x_hi, input int y_lo,
                               input int y_hi, input int travel, input int cross_lim);
    drain_results();
    program_reg(tsgd_pkg::REG_START_X_MIN, REG_W'(x_lo));
    program_reg(tsgd_pkg::REG_START_X_MAX, REG_W'(x_hi));
    program_reg(tsgd_pkg::REG_START_Y_MIN, REG_W'(y_lo));
    program_reg(tsgd_pkg::REG_START_Y_MAX, REG_W'(y_hi));
    program_reg(tsgd_pkg::REG_MIN_TRAVEL, REG_W'(travel));
    program_reg(tsgd_pkg::REG_MAX_CROSS_TRAVEL, REG_W'(cross_lim));
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COORD_BITS'(COORD_MAX);
      default: return COORD_BITS'($urandom_range(0, COORD_MAX));
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
    return COORD_BITS'(v);
  endfunction

  // One random gesture. Most are well-formed presses whose travel is aimed
  // around the current thresholds, so that classifications land on both sides
  // of every limit. The rest are noise items or presses that are queried
  // without a release.
  task automatic random_gesture();
    int sx, sy, ex, ey;
    int along, side, span, moves, dir, roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      repeat ($urandom_range(1, 4))
        send_item(KIND_W'($urandom_range(0, 3)), rand_coord(), rand_coord());
      return;
    end
    sx   = int'(rand_coord());
    sy   = int'(rand_coord());
    dir  = $urandom_range(0, 4);
    span = int'(win_cfg.max_cross_travel) + 2;
    if (span > 600) span = 600;
    along = int'(win_cfg.min_travel);
    if ($urandom_range(0, 1)) along += int'($urandom_range(0, 6)) - 3;
    else along += int'($urandom_range(0, 400));
    side = int'($urandom_range(0, 2 * span)) - span;
    case (dir)
      0: begin ex = sx + along; ey = sy + side; end
      1: begin ex = sx - along; ey = sy + side; end
      2: begin ex = sx + side;  ey = sy + along; end
      3: begin ex = sx + side;  ey = sy - along; end
      default: begin ex = int'(rand_coord()); ey = int'(rand_coord()); end
    endcase
    send_item(tsgd_pkg::KIND_SAMPLE, COORD_BITS'(sx), COORD_BITS'(sy));
    // With no further sample the query works on the stale current point.
    moves = $urandom_range(0, 3);
    for (int i = 1; i < moves; i++) begin
      send_item(tsgd_pkg::KIND_SAMPLE, rand_coord(), rand_coord());
    end
    if (moves > 0) send_item(tsgd_pkg::KIND_SAMPLE, clamp_coord(ex), clamp_coord(ey));
    if (roll < 20) begin
      // Query while the finger is still down; the press continues afterwards.
      send_item(tsgd_pkg::KIND_QUERY, rand_coord(), rand_coord());
    end else begin
      send_item(tsgd_pkg::KIND_RELEASE, rand_coord(), rand_coord());
      send_item(tsgd_pkg::KIND_QUERY, rand_coord(), rand_coord());
      if ($urandom_range(0, 4) == 0) begin
        send_item(tsgd_pkg::KIND_QUERY, rand_coord(), rand_coord());
      end
    end
  endtask

  task automatic random_phase(input int count);
    int first;
    first = items_sent;
    while (items_sent - first < count) random_gesture();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All registers must read back their reset values.
  task automatic test_register_reset();
    check_reg_read(tsgd_pkg::REG_START_X_MIN, tsgd_pkg::RST_START_X_MIN);
    check_reg_read(tsgd_pkg::REG_START_X_MAX, tsgd_pkg::RST_START_X_MAX);
    check_reg_read(tsgd_pkg::REG_START_Y_MIN, tsgd_pkg::RST_START_Y_MIN);
    check_reg_read(tsgd_pkg::REG_START_Y_MAX, tsgd_pkg::RST_START_Y_MAX);
    check_reg_read(tsgd_pkg::REG_MIN_TRAVEL, tsgd_pkg::RST_MIN_TRAVEL);
    check_reg_read(tsgd_pkg::REG_MAX_CROSS_TRAVEL, tsgd_pkg::RST_MAX_CROSS_TRAVEL);
  endtask

  // Hand-picked items with the reset setting: an unarmed query, a release
  // without a press, a single-sample press that falls back on the current
  // point left from reset, one swipe in each direction, two of them with the
  // cross travel just under its limit, an ignored item of the unused kind, and
  // a travel exactly at the minimum, which is not enough.
  task automatic test_directed_gestures();
    send_item(tsgd_pkg::KIND_QUERY, 12'd0, 12'd0);
    send_item(tsgd_pkg::KIND_RELEASE, 12'hFFF, 12'hFFF);

    send_item(tsgd_pkg::KIND_SAMPLE, 12'hFFF, 12'hFFF);
    send_item(tsgd_pkg::KIND_RELEASE, 12'd0, 12'd0);
    send_item(tsgd_pkg::KIND_QUERY, 12'hFFF, 12'd0);

    send_item(tsgd_pkg::KIND_SAMPLE, 12'd200, 12'd200);
    send_item(tsgd_pkg::KIND_SAMPLE, 12'hFFF, 12'd210);
    send_item(tsgd_pkg::KIND_RELEASE, 12'd0, 12'd0);
    send_item(tsgd_pkg::KIND_QUERY, 12'd0, 12'd0);

    send_item(tsgd_pkg::KIND_SAMPLE, 12'd3000, 12'd1000);
    send_item(tsgd_pkg::KIND_SAMPLE, 12'd2000, 12'd951);
    send_item(tsgd_pkg::KIND_RELEASE, 12'd0, 12'd0);
    send_item(tsgd_pkg::KIND_QUERY, 12'd0, 12'd0);

    send_item(tsgd_pkg::KIND_SAMPLE, 12'd500, 12'd0);
    send_item(tsgd_pkg::KIND_SAMPLE, 12'd451, 12'd101);
    send_item(tsgd_pkg::KIND_RELEASE, 12'd0, 12'd0);
    send_item(tsgd_pkg::KIND_QUERY, 12'd0, 12'd0);

    send_item(tsgd_pkg::KIND_SAMPLE, 12'd1000, 12'hFFF);
    send_item(tsgd_pkg::KIND_SAMPLE, 12'd1000, 12'd3000);
    send_item(KIND_SPARE, 12'hFFF, 12'hFFF);
    send_item(tsgd_pkg::KIND_RELEASE, 12'd0, 12'd0);
    send_item(tsgd_pkg::KIND_QUERY, 12'd0, 12'd0);

    send_item(tsgd_pkg::KIND_SAMPLE, 12'd0, 12'd0);
    send_item(tsgd_pkg::KIND_SAMPLE, 12'd100, 12'd0);
    send_item(tsgd_pkg::KIND_RELEASE, 12'd0, 12'd0);
    send_item(tsgd_pkg::KIND_QUERY, 12'd0, 12'd0);
  endtask

  // A gesture that starts outside the window is answered with none and stays
  // armed, so it is classified once the window is widened. The query after
  // that finds it disarmed.
  task automatic test_out_of_window();
    apply_setting(1000, 2000, 1000, 2000, 100, 50);
    send_item(tsgd_pkg::KIND_SAMPLE, 12'd500, 12'd1500);
    send_item(tsgd_pkg::KIND_SAMPLE, 12'd800, 12'd1500);
    send_item(tsgd_pkg::KIND_RELEASE, 12'd0, 12'd0);
    send_item(tsgd_pkg::KIND_QUERY, 12'd0, 12'd0);
    apply_setting(0, COORD_MAX, 1000, 2000, 100, 50);
    send_item(tsgd_pkg::KIND_QUERY, 12'd0, 12'd0);
    send_item(tsgd_pkg::KIND_QUERY, 12'd0, 12'd0);
  endtask

  // Random traffic under a series of settings, the extremes among them: an
  // inverted window that no start point passes, a zero minimum travel with
  // the largest cross limit, and the largest minimum travel with a zero
  // cross limit, under which nothing is ever classified.
  task automatic test_config_sweep();
    apply_setting(0, COORD_MAX, 0, COORD_MAX, 100, 50);
    random_phase(125);
    apply_setting(1000, 3000, 500, 3500, 300, 200);
    random_phase(125);
    apply_setting(COORD_MAX, 0, 0, COORD_MAX, 0, COORD_MAX);
    random_phase(100);
    apply_setting(0, COORD_MAX, 0, COORD_MAX, 0, COORD_MAX);
    random_phase(100);
    apply_setting(0, COORD_MAX, 0, COORD_MAX, COORD_MAX, 0);
    random_phase(100);
    apply_setting(0, 2047, 2048, COORD_MAX, 20, 1);
    random_phase(100);
    apply_setting(0, COORD_MAX, 0, COORD_MAX, 1, 2);
    random_phase(100);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = tsgd_pkg::KIND_SAMPLE;
    in_ch.pos_x    = '0;
    in_ch.pos_y    = '0;
    mismatch_count = 0;
    items_sent     = 0;
    idle_cycles    = 0;
    in_gaps_on     = 1'b1;
    track          = '{default: '0};
    win_cfg        = '{start_x_min:      tsgd_pkg::RST_START_X_MIN,
                       start_x_max:      tsgd_pkg::RST_START_X_MAX,
                       start_y_min:      tsgd_pkg::RST_START_Y_MIN,
                       start_y_max:      tsgd_pkg::RST_START_Y_MAX,
                       min_travel:       tsgd_pkg::RST_MIN_TRAVEL,
                       max_cross_travel: tsgd_pkg::RST_MAX_CROSS_TRAVEL};

    // Synchronous reset, released at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_reset();
    test_directed_gestures();
    test_out_of_window();
    test_config_sweep();

    // Wait for every outstanding gesture, then keep the clock running so that any
    // stray result would still be caught by the checker.
    drain_results();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("** touch_swipe_gesture_detector: PASSED **");
    end else begin
      $display("** touch_swipe_gesture_detector: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/tsgd_pkg.sv
rtl/core/tsgd_in_if.sv
rtl/core/tsgd_out_if.sv
rtl/core/tsgd_regs.sv
rtl/core/tsgd_classify.sv
rtl/core/touch_swipe_gesture_detector.sv
dv/tb_touch_swipe_gesture_detector.sv
